// File: rtl/ddep_pkg.sv
package ddep_pkg;

    localparam int HEADER_BYTES    = 14;
    localparam int MAX_UTF8_LENGTH = 255;
    localparam int QUEUE_DEPTH     = 4;
    localparam int TDATA_W         = 88;
    localparam int PAYLOAD_W       = 82;

    localparam logic [3:0]  HDR_LAST       = 4'(HEADER_BYTES - 1);
    localparam logic [7:0]  ATTR_DIR_BIT   = 8'h10;
    localparam logic [7:0]  DOT_CHAR       = 8'h2e;
    localparam logic [31:0] TWO_BYTE_MASK  = 32'hD5005508;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_PAD    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    localparam logic ERR_OVERRUN = 1'b0;
    localparam logic ERR_UNSAFE  = 1'b1;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_byte;
        logic [31:0] start_sector;
        logic [31:0] file_size;
        logic        dir_flag;
        logic [7:0]  name_length;
        logic        err_code;
        logic        table_end;
    } res_t;

    function automatic logic forbidden_byte(input logic [7:0] b);
        return (b < 8'h20) ||
               (b inside {8'h2f, 8'h5c, 8'h3a, 8'h2a, 8'h3f, 8'h22, 8'h3c, 8'h3e, 8'h7c});
    endfunction

    // UTF-8 length of one code-page byte
    function automatic logic [1:0] utf8_bytes(input logic [7:0] b);
        logic [1:0] n;
        if (b < 8'h80) begin
            n = 2'd1;
        end else if (b >= 8'ha0) begin
            n = 2'd2;
        end else begin
            n = TWO_BYTE_MASK[b[4:0]] ? 2'd2 : 2'd3;
        end
        return n;
    endfunction

endpackage

// File: rtl/ddep_front.sv
module ddep_front #(
    parameter int SECTOR_BYTES = 2048
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    in_data,
    input  logic          in_last,
    output logic          res_push,
    output ddep_pkg::res_t res_item
);
    import ddep_pkg::*;

    localparam int OFF_W = $clog2(SECTOR_BYTES);
    localparam int CMP_W = OFF_W + 2;
    localparam logic [CMP_W-1:0] SECTOR_C = CMP_W'(SECTOR_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SECTOR_BYTES - 1);

    logic [OFF_W-1:0] offset_reg, offset_next;
    phase_t           phase_reg, phase_next;
    logic [3:0]       hidx_reg, hidx_next;
    logic [31:0]      sector_reg, sector_next;
    logic [31:0]      size_reg, size_next;
    logic [7:0]       attr_reg, attr_next;
    logic [7:0]       nlen_reg, nlen_next;
    logic             zero_reg, zero_next;
    logic             ones_reg, ones_next;
    logic [7:0]       ncount_reg, ncount_next;
    logic [9:0]       utf8_reg, utf8_next;
    logic [1:0]       dots_reg, dots_next;
    logic             unsafe_reg, unsafe_next;

    logic [OFF_W-1:0] off_inc;
    logic [CMP_W-1:0] off_wide;
    logic             hdr_no_room, zero_upd, ones_upd, hdr_blank, name_overrun;
    logic [7:0]       cnt_upd;
    logic [9:0]       utf8_upd;
    logic [1:0]       dots_upd;
    logic             unsafe_upd, name_more, name_bad;
    logic             has_res;

    assign off_inc      = (offset_reg == OFF_LAST) ? '0 : offset_reg + 1'b1;
    assign off_wide     = CMP_W'(offset_reg);
    assign hdr_no_room  = (hidx_reg == '0) && (off_wide + CMP_W'(HEADER_BYTES) > SECTOR_C);
    assign zero_upd     = ((hidx_reg == '0) | zero_reg) & (in_data == 8'h00);
    assign ones_upd     = ((hidx_reg == '0) | ones_reg) & (in_data == 8'hff);
    assign hdr_blank    = zero_upd | ones_upd;
    assign name_overrun = (off_wide + CMP_W'(1) + CMP_W'(in_data)) > SECTOR_C;

    assign cnt_upd    = ncount_reg + 8'd1;
    assign utf8_upd   = utf8_reg + 10'(utf8_bytes(in_data));
    assign dots_upd   = (in_data == DOT_CHAR) ? ((dots_reg == 2'd3) ? 2'd3 : dots_reg + 2'd1)
                                              : 2'd3;
    assign unsafe_upd = unsafe_reg | forbidden_byte(in_data);
    assign name_more  = cnt_upd < nlen_reg;
    assign name_bad   = unsafe_upd || dots_upd == 2'd1 || dots_upd == 2'd2 ||
                        utf8_upd > 10'(MAX_UTF8_LENGTH);

    // result of the current byte
    always_comb begin
        res_item = '0;
        has_res  = 1'b0;
        case (phase_reg)
            PH_HEADER: begin
                if (!hdr_no_room && hidx_reg == HDR_LAST && !hdr_blank) begin
                    if (name_overrun) begin
                        has_res           = 1'b1;
                        res_item.kind     = KIND_ERROR;
                        res_item.err_code = ERR_OVERRUN;
                    end else if (in_data == 8'h00) begin
                        has_res           = 1'b1;
                        res_item.kind     = KIND_ERROR;
                        res_item.err_code = ERR_UNSAFE;
                    end
                end
            end
            PH_NAME: begin
                has_res = 1'b1;
                if (name_more) begin
                    res_item.kind      = KIND_NAME;
                    res_item.name_byte = in_data;
                end else if (name_bad) begin
                    res_item.kind     = KIND_ERROR;
                    res_item.err_code = ERR_UNSAFE;
                end else begin
                    res_item.kind         = KIND_ENTRY;
                    res_item.name_byte    = in_data;
                    res_item.start_sector = sector_reg;
                    res_item.file_size    = size_reg;
                    res_item.dir_flag     = |(attr_reg & ATTR_DIR_BIT);
                    res_item.name_length  = nlen_reg;
                end
            end
            default: begin
            end
        endcase
        if (in_last && !has_res) begin
            res_item.kind = KIND_END;
        end
        res_item.table_end = in_last;
    end

    assign res_push = in_accept && (has_res || in_last);

    // next parser state
    always_comb begin
        offset_next = offset_reg;
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        sector_next = sector_reg;
        size_next   = size_reg;
        attr_next   = attr_reg;
        nlen_next   = nlen_reg;
        zero_next   = zero_reg;
        ones_next   = ones_reg;
        ncount_next = ncount_reg;
        utf8_next   = utf8_reg;
        dots_next   = dots_reg;
        unsafe_next = unsafe_reg;
        if (in_accept) begin
            offset_next = off_inc;
            case (phase_reg)
                PH_HEADER: begin
                    if (hdr_no_room) begin
                        phase_next = (off_inc == '0) ? PH_HEADER : PH_SKIP;
                    end else begin
                        zero_next = zero_upd;
                        ones_next = ones_upd;
                        if (hidx_reg == '0) begin
                            sector_next = '0;
                            size_next   = '0;
                            attr_next   = '0;
                            nlen_next   = '0;
                        end
                        case (hidx_reg)
                            4'd4:    sector_next[7:0]   = in_data;
                            4'd5:    sector_next[15:8]  = in_data;
                            4'd6:    sector_next[23:16] = in_data;
                            4'd7:    sector_next[31:24] = in_data;
                            4'd8:    size_next[7:0]     = in_data;
                            4'd9:    size_next[15:8]    = in_data;
                            4'd10:   size_next[23:16]   = in_data;
                            4'd11:   size_next[31:24]   = in_data;
                            4'd12:   attr_next          = in_data;
                            4'd13:   nlen_next          = in_data;
                            default: begin
                            end
                        endcase
                        if (hidx_reg != HDR_LAST) begin
                            hidx_next = hidx_reg + 4'd1;
                        end else begin
                            hidx_next = '0;
                            if (hdr_blank) begin
                                phase_next = (off_inc == '0) ? PH_HEADER : PH_SKIP;
                            end else if (name_overrun || in_data == 8'h00) begin
                                phase_next = PH_ERROR;
                            end else begin
                                phase_next  = PH_NAME;
                                ncount_next = '0;
                                utf8_next   = '0;
                                dots_next   = '0;
                                unsafe_next = 1'b0;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    ncount_next = cnt_upd;
                    utf8_next   = utf8_upd;
                    dots_next   = dots_upd;
                    unsafe_next = unsafe_upd;
                    if (!name_more) begin
                        if (name_bad) begin
                            phase_next = PH_ERROR;
                        end else begin
                            phase_next = (off_inc[1:0] == 2'b00) ? PH_HEADER : PH_PAD;
                        end
                    end
                end
                PH_PAD: begin
                    phase_next = (off_inc[1:0] == 2'b00) ? PH_HEADER : PH_PAD;
                end
                PH_SKIP: begin
                    phase_next = (off_inc == '0) ? PH_HEADER : PH_SKIP;
                end
                default: begin
                end
            endcase
            if (in_last) begin
                offset_next = '0;
                phase_next  = PH_HEADER;
                hidx_next   = '0;
                sector_next = '0;
                size_next   = '0;
                attr_next   = '0;
                nlen_next   = '0;
                zero_next   = 1'b1;
                ones_next   = 1'b1;
                ncount_next = '0;
                utf8_next   = '0;
                dots_next   = '0;
                unsafe_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            sector_reg <= '0;
            size_reg   <= '0;
            attr_reg   <= '0;
            nlen_reg   <= '0;
            zero_reg   <= 1'b1;
            ones_reg   <= 1'b1;
            ncount_reg <= '0;
            utf8_reg   <= '0;
            dots_reg   <= '0;
            unsafe_reg <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            sector_reg <= sector_next;
            size_reg   <= size_next;
            attr_reg   <= attr_next;
            nlen_reg   <= nlen_next;
            zero_reg   <= zero_next;
            ones_reg   <= ones_next;
            ncount_reg <= ncount_next;
            utf8_reg   <= utf8_next;
            dots_reg   <= dots_next;
            unsafe_reg <= unsafe_next;
        end
    end

endmodule

// File: rtl/ddep_queue.sv
module ddep_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ddep_pkg::res_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ddep_pkg::res_t pop_item
);
    import ddep_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    res_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ddep_back.sv
module ddep_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  ddep_pkg::res_t                 q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ddep_pkg::TDATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import ddep_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t out_item_reg;
    logic load;

    assign load  = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = load;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_item_reg <= q_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W-PAYLOAD_W)'(0),
                       out_item_reg.err_code,
                       out_item_reg.name_length,
                       out_item_reg.dir_flag,
                       out_item_reg.file_size,
                       out_item_reg.start_sector,
                       out_item_reg.name_byte};
    assign m_tuser  = out_item_reg.kind;
    assign m_tlast  = out_item_reg.table_end;

endmodule

// File: rtl/disc_directory_entry_parser_unit.sv
// Disc directory entry parser.
// Input: one directory table byte per item on s_tdata[7:0]; s_tlast marks the
// final byte of the table's last sector. The table arrives in whole sectors of
// SECTOR_BYTES bytes.
// Output: zero or one item per input byte. m_tuser is the kind (name byte,
// entry complete, error, end of table); m_tlast is set on the item caused by
// the table's last byte. m_tdata carries name byte, start sector, file size,
// directory bit, name length and error code.
// Throughput is one byte per cycle while the queue is not full. The parser
// updates its counters and flags in the cycle it takes a byte; results go
// through a four-item queue into an output register that drives the m_ side.
// When m_tready is held low the queue fills and s_tready drops once it is
// full; no item is lost. After an error the block stays silent until the
// table's last byte, which returns all parsing state to reset.
// aresetn is synchronous, active low, and clears parser, queue and output.
module disc_directory_entry_parser_unit #(
    parameter int SECTOR_BYTES = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte
    input  logic                         s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // name_byte[7:0], start_sector[39:8], file_size[71:40], dir_flag[72],
    // name_length[80:73], err_code[81], zero[87:82]
    output logic [ddep_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // result_kind
    output logic                         m_tlast    // table_end
);
    import ddep_pkg::*;

    logic in_accept;
    logic res_push;
    res_t res_item;
    logic q_full, q_valid, q_pop;
    res_t q_item;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    ddep_front #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    ddep_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_item (res_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    ddep_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/ddep_checker.sv
module ddep_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ddep_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import ddep_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("stalled output item changed");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast && m_tdata == '0)
        else $error("end of table item malformed");

    a_name_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NAME |-> m_tdata[TDATA_W-1:8] == '0)
        else $error("name byte item carries entry fields");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[80:0] == '0)
        else $error("error item carries entry fields");

endmodule

bind disc_directory_entry_parser_unit ddep_checker u_ddep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
